// ===== rtl/core/g2e_pkg.sv =====
// Shared constants, the CORDIC arctangent table and the Q30 clamp for the
// geodetic to ECEF pipeline. No dependencies.
`default_nettype none
package g2e_pkg;

  localparam int COORD_W = 34;

  // range limits in microdegrees
  localparam logic signed [27:0] LAT_LIMIT = 28'sd90000000;
  localparam logic signed [28:0] LON_LIMIT = 29'sd180000000;

  // binary angle: round(mag * 2^26 / 5625000) = floor((mag * 2^23 + 351562) / 703125),
  // estimated by a reciprocal in Q51 that is never more than one short
  localparam logic [19:0]      BAM_DIV      = 20'd703125;
  localparam logic [18:0]      BAM_HALF     = 19'd351562;
  localparam logic [31:0]      BAM_RECIP    = 32'((64'd1 << 51) / 64'(BAM_DIV));
  localparam logic [27:0]      BAM_BIAS     = 28'((64'(BAM_HALF) * 64'(BAM_RECIP)) >> 23);
  localparam logic [31:0]      QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0]      HALF_TURN    = 32'h8000_0000;

  // CORDIC gain and unity in Q30
  localparam logic signed [33:0] GAIN_Q30 = 34'sd652032874;
  localparam logic signed [33:0] ONE_Q30  = 34'sd1073741824;

  // ellipsoid
  localparam logic [32:0]        E2_Q40 = 33'd7360548640;
  localparam logic signed [31:0] E2_Q37 = 32'sd920068580;
  localparam logic [32:0]        A_MM   = 33'd6378137000;
  localparam logic [31:0]        A_MM_TOP = 32'(A_MM >> 2);
  localparam logic [48:0]        A_MM_LO  = {A_MM[1:0], 47'd0};
  localparam logic [62:0]        W_ONE    = 63'(1) << 62;

  function automatic logic [29:0] atan_lut(input int unsigned idx);
    logic [29:0] v;
    unique case (idx)
      0:  v = 30'd536870912;
      1:  v = 30'd316933406;
      2:  v = 30'd167458907;
      3:  v = 30'd85004756;
      4:  v = 30'd42667331;
      5:  v = 30'd21354465;
      6:  v = 30'd10679838;
      7:  v = 30'd5340245;
      8:  v = 30'd2670163;
      9:  v = 30'd1335087;
      10: v = 30'd667544;
      11: v = 30'd333772;
      12: v = 30'd166886;
      13: v = 30'd83443;
      14: v = 30'd41722;
      15: v = 30'd20861;
      16: v = 30'd10430;
      17: v = 30'd5215;
      18: v = 30'd2608;
      19: v = 30'd1304;
      20: v = 30'd652;
      21: v = 30'd326;
      22: v = 30'd163;
      23: v = 30'd81;
      24: v = 30'd41;
      25: v = 30'd20;
      26: v = 30'd10;
      27: v = 30'd5;
      28: v = 30'd3;
      29: v = 30'd1;
      30: v = 30'd1;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [31:0] clamp_q30(input logic signed [33:0] v);
    logic signed [31:0] r;
    if (v > ONE_Q30) begin
      r = 32'sd1073741824;
    end else if (v < -ONE_Q30) begin
      r = -32'sd1073741824;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/g2e_delay.sv =====
// Enabled delay line for payload that rides alongside the arithmetic.
// No dependencies.
`default_nettype none
module g2e_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] tap_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      tap_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        tap_r[i] <= tap_r[i-1];
      end
    end
  end

  assign q_o = tap_r[DEPTH-1];

endmodule
`default_nettype wire

// ===== rtl/core/g2e_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
// No package dependency.
`default_nettype none
module g2e_div #(
  parameter int NW = 32,
  parameter int DW = 23
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem_i,
  input  logic [NW-1:0] lo_i,
  input  logic [DW-1:0] den_i,
  output logic [NW-1:0] quo_o
);

  logic [DW-1:0] rem_w [NW+1];
  logic [NW-1:0] ql_w  [NW+1];
  logic [DW-1:0] den_w [NW+1];
  logic [DW-1:0] rem_r [NW];
  logic [NW-1:0] ql_r  [NW];
  logic [DW-1:0] den_r [NW];

  assign rem_w[0] = rem_i;
  assign ql_w[0]  = lo_i;
  assign den_w[0] = den_i;

  for (genvar i = 0; i < NW; i++) begin : g_stage
    logic [DW:0] rs, diff;
    logic        ge;
    assign rs   = {rem_w[i], ql_w[i][NW-1]};
    assign diff = rs - {1'b0, den_w[i]};
    assign ge   = rs >= {1'b0, den_w[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= ge ? diff[DW-1:0] : rs[DW-1:0];
        ql_r[i]  <= {ql_w[i][NW-2:0], ge};
        den_r[i] <= den_w[i];
      end
    end
    assign rem_w[i+1] = rem_r[i];
    assign ql_w[i+1]  = ql_r[i];
    assign den_w[i+1] = den_r[i];
  end

  assign quo_o = ql_w[NW];

endmodule
`default_nettype wire

// ===== rtl/core/g2e_sqrt.sv =====
// Pipelined rounded integer square root, two radicand bits per stage.
// No package dependency.
`default_nettype none
module g2e_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [62:0] n_i,
  output logic [31:0] root_o
);

  localparam int STEPS = 32;

  logic [62:0] n_w   [STEPS+1];
  logic [62:0] res_w [STEPS+1];
  logic [62:0] n_r   [STEPS];
  logic [62:0] res_r [STEPS];
  logic [31:0] root_r;

  assign n_w[0]   = n_i;
  assign res_w[0] = '0;

  for (genvar i = 0; i < STEPS; i++) begin : g_stage
    localparam logic [62:0] BIT = 63'(1) << (62 - 2 * i);
    logic [62:0] sum;
    logic        ge;
    assign sum = res_w[i] + BIT;
    assign ge  = n_w[i] >= sum;
    always_ff @(posedge clk) begin
      if (en) begin
        n_r[i]   <= ge ? n_w[i] - sum : n_w[i];
        res_r[i] <= ge ? (res_w[i] >> 1) + BIT : res_w[i] >> 1;
      end
    end
    assign n_w[i+1]   = n_r[i];
    assign res_w[i+1] = res_r[i];
  end

  // round to nearest
  always_ff @(posedge clk) begin
    if (en) begin
      root_r <= res_w[STEPS][31:0] + 32'(n_w[STEPS] > res_w[STEPS]);
    end
  end

  assign root_o = root_r;

endmodule
`default_nettype wire

// ===== rtl/core/g2e_cordic.sv =====
// Rotation-mode CORDIC giving clamped Q30 cosine and sine of a binary angle.
// Depends on g2e_pkg for the gain, the arctangent table and the clamp.
`default_nettype none
module g2e_cordic
  import g2e_pkg::*;
#(
  parameter int STAGES = 32
) (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] ang_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);

  logic signed [33:0] x_w [STAGES+1];
  logic signed [33:0] y_w [STAGES+1];
  logic signed [32:0] z_w [STAGES+1];
  logic signed [33:0] x_r [STAGES];
  logic signed [33:0] y_r [STAGES];
  logic signed [32:0] z_r [STAGES];
  logic signed [31:0] cos_r, sin_r;

  assign x_w[0] = GAIN_Q30;
  assign y_w[0] = '0;
  assign z_w[0] = {ang_i[31], ang_i};

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic signed [33:0] dx, dy;
    logic signed [32:0] t;
    assign dx = y_w[i] >>> i;
    assign dy = x_w[i] >>> i;
    assign t  = $signed({3'b000, atan_lut(i)});
    always_ff @(posedge clk) begin
      if (en) begin
        if (!z_w[i][32]) begin
          x_r[i] <= x_w[i] - dx;
          y_r[i] <= y_w[i] + dy;
          z_r[i] <= z_w[i] - t;
        end else begin
          x_r[i] <= x_w[i] + dx;
          y_r[i] <= y_w[i] - dy;
          z_r[i] <= z_w[i] + t;
        end
      end
    end
    assign x_w[i+1] = x_r[i];
    assign y_w[i+1] = y_r[i];
    assign z_w[i+1] = z_r[i];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cos_r <= clamp_q30(x_w[STAGES]);
      sin_r <= clamp_q30(y_w[STAGES]);
    end
  end

  assign cos_o = cos_r;
  assign sin_o = sin_r;

endmodule
`default_nettype wire

// ===== rtl/core/g2e_mulq30.sv =====
// Four-stage signed multiply by a Q30 factor, rounded half away from zero.
// No package dependency.
`default_nettype none
module g2e_mulq30 #(
  parameter int HW = 51
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [HW-1:0] h_i,
  input  logic signed [31:0]   c_i,
  output logic signed [HW-1:0] p_o
);

  localparam int PW = HW - 20 + 31;

  logic [HW-1:0] hneg;
  logic [31:0]   cneg;
  logic          neg1_r, neg2_r, neg3_r;
  logic [HW-1:0] mag_r;
  logic [30:0]   k_r;
  logic [PW-1:0] phi_r;
  logic [50:0]   plo_r;
  logic [51:0]   low;
  logic [HW:0]   sum;
  logic [HW-1:0] r_r;
  logic signed [HW-1:0] p_r;

  assign hneg = -h_i;
  assign cneg = -c_i;
  assign low  = 52'({phi_r[9:0], 20'd0}) + 52'(plo_r) + (52'(1) << 29);
  assign sum  = (HW+1)'(phi_r[PW-1:10]) + (HW+1)'(low[51:30]);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= h_i[HW-1] ^ c_i[31];
      mag_r  <= h_i[HW-1] ? hneg : h_i;
      k_r    <= c_i[31] ? cneg[30:0] : c_i[30:0];
      neg2_r <= neg1_r;
      phi_r  <= mag_r[HW-1:20] * k_r;
      plo_r  <= mag_r[19:0] * k_r;
      neg3_r <= neg2_r;
      r_r    <= sum[HW-1:0];
      p_r    <= neg3_r ? -$signed(r_r) : $signed(r_r);
    end
  end

  assign p_o = p_r;

endmodule
`default_nettype wire

// ===== rtl/core/g2e_round.sv =====
// Three-stage Q16 to whole-millimetre rounding, half away from zero.
// Depends on g2e_pkg for the coordinate width.
`default_nettype none
module g2e_round
  import g2e_pkg::*;
#(
  parameter int VW = 51
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [VW-1:0]      v_i,
  output logic signed [COORD_W-1:0] mm_o
);

  logic [VW-1:0] vneg;
  logic [VW:0]   rsum;
  logic          neg1_r, neg2_r;
  logic [VW-1:0] mag_r;
  logic [VW-16:0] r_r;
  logic signed [COORD_W-1:0] mm_r;

  assign vneg = -v_i;
  assign rsum = (VW+1)'(mag_r) + (VW+1)'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= v_i[VW-1];
      mag_r  <= v_i[VW-1] ? vneg : v_i;
      neg2_r <= neg1_r;
      r_r    <= rsum[VW:16];
      mm_r   <= neg2_r ? -$signed(r_r[COORD_W-1:0]) : $signed(r_r[COORD_W-1:0]);
    end
  end

  assign mm_o = mm_r;

endmodule
`default_nettype wire

// ===== rtl/core/geodetic_to_ecef_top.sv =====
// WGS-84 geodetic to ECEF converter: latitude/longitude in microdegrees and
// height in mm in, X/Y/Z in mm out. Depends on g2e_pkg and all g2e_* modules.
//
// The block is one stall-as-a-whole pipeline that takes a point every cycle
// and returns it through a chain of stages: a four-stage reciprocal multiply
// with one compare and subtract that turns microdegrees into a binary angle,
// the CORDIC (one stage per rotation plus a clamp), a 33-stage square root for
// the prime-vertical radius and a 49-stage divider for the radius itself, then
// split Q30 multiplies and the final rounding. When a finished result is not
// taken, every stage holds and in_ready drops; nothing is lost or repeated.
// A point outside +-90 degrees of latitude or +-180 degrees of longitude comes
// out with zero coordinates and range_error set. There is no configuration and
// no state beyond the pipeline.
`default_nettype none
module geodetic_to_ecef_top
  import g2e_pkg::*;
#(
  parameter int CORDIC_STAGES = 32
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [27:0]        in_lat_microdeg,
  input  logic signed [28:0]        in_lon_microdeg,
  input  logic signed [27:0]        in_alt_mm,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [COORD_W-1:0] out_ecef_x_mm,
  output logic signed [COORD_W-1:0] out_ecef_y_mm,
  output logic signed [COORD_W-1:0] out_ecef_z_mm,
  output logic                      out_range_error
);

  // pipeline length and the tap where the root is valid
  localparam int LAT      = CORDIC_STAGES + 108;
  localparam int ROOT_TAP = CORDIC_STAGES + 43;

  logic pipe_en;
  logic in_err;

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] err_line_r;

  // advance unless the last stage holds a result nobody takes
  assign pipe_en  = !vld_r[LAT-1] || out_ready;
  assign in_ready = pipe_en;

  assign in_err = (in_lat_microdeg < -LAT_LIMIT) || (in_lat_microdeg > LAT_LIMIT) ||
                  (in_lon_microdeg < -LON_LIMIT) || (in_lon_microdeg > LON_LIMIT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (pipe_en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      err_line_r <= {err_line_r[LAT-2:0], in_err};
    end
  end

  // capture: magnitudes, masked to zero for out-of-range points
  logic [27:0] lat_abs;
  logic [28:0] lon_abs;
  logic        lat_neg_r, lon_neg_r;
  logic [26:0] lat_mag_r;
  logic [27:0] lon_mag_r;
  logic signed [27:0] alt_r;

  assign lat_abs = in_lat_microdeg[27] ? -in_lat_microdeg : in_lat_microdeg;
  assign lon_abs = in_lon_microdeg[28] ? -in_lon_microdeg : in_lon_microdeg;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lat_neg_r <= in_lat_microdeg[27];
      lon_neg_r <= in_lon_microdeg[28];
      lat_mag_r <= in_err ? '0 : lat_abs[26:0];
      lon_mag_r <= in_err ? '0 : lon_abs[27:0];
      alt_r     <= in_alt_mm;
    end
  end

  // binary angle: multiply by the reciprocal for an estimate at most one
  // short, then check the remainder and bump the quotient where it is
  logic [59:0] lat_prod_r, lon_prod_r;
  logic [50:0] lat_num_r, lon_num_r, lat_num2_r, lon_num2_r;
  logic [50:0] lat_num3_r, lon_num3_r;
  logic [60:0] lat_est, lon_est;
  logic [31:0] lat_qe_r, lon_qe_r, lat_qe2_r, lon_qe2_r;
  logic [51:0] lat_qd_r, lon_qd_r;
  logic [51:0] lat_rem, lon_rem;
  logic [31:0] lat_q_r, lon_q_r;

  assign lat_est = 61'(lat_prod_r) + 61'(BAM_BIAS);
  assign lon_est = 61'(lon_prod_r) + 61'(BAM_BIAS);
  assign lat_rem = 52'(lat_num3_r) - lat_qd_r;
  assign lon_rem = 52'(lon_num3_r) - lon_qd_r;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lat_prod_r <= 60'(lat_mag_r) * 60'(BAM_RECIP);
      lon_prod_r <= 60'(lon_mag_r) * 60'(BAM_RECIP);
      lat_num_r  <= 51'({lat_mag_r, 23'd0}) + 51'(BAM_HALF);
      lon_num_r  <= 51'({lon_mag_r, 23'd0}) + 51'(BAM_HALF);
      lat_qe_r   <= lat_est[59:28];
      lon_qe_r   <= lon_est[59:28];
      lat_num2_r <= lat_num_r;
      lon_num2_r <= lon_num_r;
      lat_qd_r   <= 52'(lat_qe_r) * 52'(BAM_DIV);
      lon_qd_r   <= 52'(lon_qe_r) * 52'(BAM_DIV);
      lat_qe2_r  <= lat_qe_r;
      lon_qe2_r  <= lon_qe_r;
      lat_num3_r <= lat_num2_r;
      lon_num3_r <= lon_num2_r;
      lat_q_r    <= lat_qe2_r + 32'(lat_rem >= 52'(BAM_DIV));
      lon_q_r    <= lon_qe2_r + 32'(lon_rem >= 52'(BAM_DIV));
    end
  end

  logic [1:0] sgn_d;
  g2e_delay #(.W(2), .DEPTH(4)) u_sgn_dly (
    .clk(clk), .en(pipe_en), .d_i({lat_neg_r, lon_neg_r}), .q_o(sgn_d)
  );

  // fold longitude beyond a quarter turn by half a turn, negate later
  logic        lon_big;
  logic [31:0] lat_p_r, lon_p_r;
  logic        lat_s_r, lon_s_r, flip_r;
  logic signed [31:0] lat_ang_r, lon_ang_r;

  assign lon_big = lon_q_r > QUARTER_TURN;

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      lat_p_r   <= lat_q_r;
      lat_s_r   <= sgn_d[1];
      lon_p_r   <= lon_big ? HALF_TURN - lon_q_r : lon_q_r;
      lon_s_r   <= sgn_d[0] ^ lon_big;
      flip_r    <= lon_big;
      lat_ang_r <= lat_s_r ? -$signed(lat_p_r) : $signed(lat_p_r);
      lon_ang_r <= lon_s_r ? -$signed(lon_p_r) : $signed(lon_p_r);
    end
  end

  logic signed [31:0] clat, slat, clon, slon;
  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_lat_cordic (
    .clk(clk), .en(pipe_en), .ang_i(lat_ang_r), .cos_o(clat), .sin_o(slat)
  );
  g2e_cordic #(.STAGES(CORDIC_STAGES)) u_lon_cordic (
    .clk(clk), .en(pipe_en), .ang_i(lon_ang_r), .cos_o(clon), .sin_o(slon)
  );

  logic flip_d;
  g2e_delay #(.W(1), .DEPTH(CORDIC_STAGES + 2)) u_flip_dly (
    .clk(clk), .en(pipe_en), .d_i(flip_r), .q_o(flip_d)
  );

  logic signed [31:0] clon_f, slon_f;
  assign clon_f = flip_d ? -clon : clon;
  assign slon_f = flip_d ? -slon : slon;

  // e2 * sin^2 in Q62, then 1 - e2 sin^2
  logic signed [63:0] sq_full;
  logic [63:0]        term_full;
  logic [60:0]        sq_r;
  logic [54:0]        term_r;
  logic [62:0]        w_r;

  assign sq_full   = slat * slat;
  assign term_full = 64'(E2_Q40) * 64'(sq_r[60:30]);

  always_ff @(posedge clk) begin
    if (pipe_en) begin
      sq_r   <= sq_full[60:0];
      term_r <= term_full[62:8];
      w_r    <= W_ONE - 63'(term_r);
    end
  end

  logic [31:0] root;
  g2e_sqrt u_sqrt (.clk(clk), .en(pipe_en), .n_i(w_r), .root_o(root));

  logic [48:0] rn;
  g2e_div #(.NW(49), .DW(32)) u_radius (
    .clk(clk), .en(pipe_en), .rem_i(A_MM_TOP), .lo_i(A_MM_LO), .den_i(root), .quo_o(rn)
  );

  // heights in Q16 alongside the radius
  logic signed [27:0] alt_d1, alt_d2;
  g2e_delay #(.W(28), .DEPTH(CORDIC_STAGES + 92)) u_alt_dly1 (
    .clk(clk), .en(pipe_en), .d_i(alt_r), .q_o(alt_d1)
  );
  g2e_delay #(.W(28), .DEPTH(7)) u_alt_dly2 (
    .clk(clk), .en(pipe_en), .d_i(alt_d1), .q_o(alt_d2)
  );

  logic signed [50:0] alt_q16_a, alt_q16_b;
  assign alt_q16_a = {{7{alt_d1[27]}}, alt_d1, 16'd0};
  assign alt_q16_b = {{7{alt_d2[27]}}, alt_d2, 16'd0};

  logic signed [50:0] h_r, rn_r;
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      h_r  <= $signed({2'b00, rn}) + alt_q16_a;
      rn_r <= $signed({2'b00, rn});
    end
  end

  logic signed [31:0] clat_d, slat_d, clon_d, slon_d;
  g2e_delay #(.W(32), .DEPTH(86)) u_clat_dly (
    .clk(clk), .en(pipe_en), .d_i(clat), .q_o(clat_d)
  );
  g2e_delay #(.W(32), .DEPTH(93)) u_slat_dly (
    .clk(clk), .en(pipe_en), .d_i(slat), .q_o(slat_d)
  );
  g2e_delay #(.W(32), .DEPTH(90)) u_clon_dly (
    .clk(clk), .en(pipe_en), .d_i(clon_f), .q_o(clon_d)
  );
  g2e_delay #(.W(32), .DEPTH(90)) u_slon_dly (
    .clk(clk), .en(pipe_en), .d_i(slon_f), .q_o(slon_d)
  );

  logic signed [50:0] t_p, e2_p;
  g2e_mulq30 #(.HW(51)) u_mul_t (
    .clk(clk), .en(pipe_en), .h_i(h_r), .c_i(clat_d), .p_o(t_p)
  );
  g2e_mulq30 #(.HW(51)) u_mul_e2 (
    .clk(clk), .en(pipe_en), .h_i(rn_r), .c_i(E2_Q37), .p_o(e2_p)
  );

  // polar radius term N(1 - e2), then add height
  logic signed [50:0] rn_d5;
  g2e_delay #(.W(51), .DEPTH(5)) u_rn_dly (
    .clk(clk), .en(pipe_en), .d_i(rn_r), .q_o(rn_d5)
  );

  logic signed [50:0] q7_r, rz_r, hz_r;
  always_ff @(posedge clk) begin
    if (pipe_en) begin
      q7_r <= (e2_p + 51'sd64) >>> 7;
      rz_r <= rn_d5 - q7_r;
      hz_r <= rz_r + alt_q16_b;
    end
  end

  logic signed [50:0] x_p, y_p, z_p, x_d, y_d;
  g2e_mulq30 #(.HW(51)) u_mul_x (
    .clk(clk), .en(pipe_en), .h_i(t_p), .c_i(clon_d), .p_o(x_p)
  );
  g2e_mulq30 #(.HW(51)) u_mul_y (
    .clk(clk), .en(pipe_en), .h_i(t_p), .c_i(slon_d), .p_o(y_p)
  );
  g2e_mulq30 #(.HW(51)) u_mul_z (
    .clk(clk), .en(pipe_en), .h_i(hz_r), .c_i(slat_d), .p_o(z_p)
  );

  // hold X and Y until Z catches up
  g2e_delay #(.W(51), .DEPTH(3)) u_x_dly (
    .clk(clk), .en(pipe_en), .d_i(x_p), .q_o(x_d)
  );
  g2e_delay #(.W(51), .DEPTH(3)) u_y_dly (
    .clk(clk), .en(pipe_en), .d_i(y_p), .q_o(y_d)
  );

  logic signed [COORD_W-1:0] x_mm, y_mm, z_mm;
  g2e_round #(.VW(51)) u_rnd_x (.clk(clk), .en(pipe_en), .v_i(x_d), .mm_o(x_mm));
  g2e_round #(.VW(51)) u_rnd_y (.clk(clk), .en(pipe_en), .v_i(y_d), .mm_o(y_mm));
  g2e_round #(.VW(51)) u_rnd_z (.clk(clk), .en(pipe_en), .v_i(z_p), .mm_o(z_mm));

  // drop coordinates of out-of-range points
  assign out_valid       = vld_r[LAT-1];
  assign out_range_error = err_line_r[LAT-1];
  assign out_ecef_x_mm   = err_line_r[LAT-1] ? '0 : x_mm;
  assign out_ecef_y_mm   = err_line_r[LAT-1] ? '0 : y_mm;
  assign out_ecef_z_mm   = err_line_r[LAT-1] ? '0 : z_mm;

  // an accepted transfer enters the first stage
  a_accept_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> vld_r[0])
    else $error("accepted transfer missing from first stage");

  // a stall freezes every valid bit
  a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |=> vld_r == $past(vld_r))
    else $error("valid bits moved during a stall");

  // the radius divisor is never zero
  a_root_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ROOT_TAP] |-> root != 32'd0)
    else $error("zero square root feeding the radius divider");

endmodule
`default_nettype wire
